// ===== src/efcc_pkg.sv =====
// Shared constants, types and the CRC step for the escaped frame CRC checker.
// No dependencies; every other file of the block uses it by scoped names.
package efcc_pkg;

    localparam int          PAYLOAD_LEN_DEF = 16;
    localparam int          BYTE_W          = 8;
    localparam int          POS_W           = 5;
    localparam int          CRC_W           = 16;

    localparam logic [7:0]  FLAG_BYTE = 8'h7e;
    localparam logic [7:0]  ESC_BYTE  = 8'h7d;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_INIT  = 16'hffff;

    // controller -> datapath
    typedef struct packed {
        logic rx_en;     // take line bytes
        logic burst_en;  // stream the stored frame out
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic frame_done;  // accepted byte completed a frame
        logic burst_done;  // last frame byte loaded into the output stage
    } dp_status_t;

    // One byte of reflected CRC-CCITT (poly 0x8408), table-free form.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0]  t;
        logic [15:0] r;
        t = data ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        r = {t, crc[15:8]};
        r = r ^ {12'h000, t[7:4]};
        r = r ^ {5'b00000, t, 3'b000};
        return r;
    endfunction

endpackage

// ===== src/efcc_ctrl.sv =====
// Frame controller: receive state and output burst state.
// Depends on efcc_pkg for the command and status structs.
module efcc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  efcc_pkg::dp_status_t status,
    output efcc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_RECV  = 2'b01,
        S_BURST = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_RECV:
            begin
                if (status.frame_done)
                    state_next = S_BURST;
            end
            S_BURST:
            begin
                if (status.burst_done)
                    state_next = S_RECV;
            end
            default: state_next = S_RECV;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_RECV;
        else
            state_reg <= state_next;
    end

    assign cmd.rx_en    = (state_reg == S_RECV);
    assign cmd.burst_en = (state_reg == S_BURST);

endmodule

// ===== src/efcc_datapath.sv =====
// Datapath: destuffing, running CRC, frame store memory and output stage.
// Depends on efcc_pkg for constants, the CRC step and the control structs.
module efcc_datapath #(
    parameter int PAYLOAD_LEN = efcc_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  efcc_pkg::ctrl_cmd_t        cmd,
    output efcc_pkg::dp_status_t       status,
    input  logic                      rx_valid,
    output logic                      rx_ready,
    input  logic [efcc_pkg::BYTE_W-1:0] rx_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [efcc_pkg::BYTE_W-1:0] frame_byte,
    output logic [efcc_pkg::POS_W-1:0]  byte_position,
    output logic                      last_of_frame,
    output logic                      crc_ok
);

    localparam int FRAME_LEN = PAYLOAD_LEN + 2;
    localparam int CNT_W     = $clog2(FRAME_LEN);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] PAY_IDX  = CNT_W'(PAYLOAD_LEN);

    logic [efcc_pkg::BYTE_W-1:0] store_mem [FRAME_LEN];

    logic [CNT_W-1:0]            fill_reg;
    logic                        sync_reg;
    logic                        esc_reg;
    logic [efcc_pkg::CRC_W-1:0]  crc_reg;
    logic [efcc_pkg::BYTE_W-1:0] crc_hi_reg;
    logic                        ok_reg;
    logic [CNT_W-1:0]            rd_idx_reg;
    logic                        out_valid_reg;
    logic [efcc_pkg::BYTE_W-1:0] out_byte_reg;
    logic [CNT_W-1:0]            out_idx_reg;
    logic                        out_last_reg;
    logic                        out_ok_reg;

    logic                        rx_acc;
    logic                        is_flag;
    logic                        is_esc;
    logic                        data_en;
    logic                        frame_last;
    logic [efcc_pkg::BYTE_W-1:0] dec_byte;
    logic                        load;
    logic [CNT_W+efcc_pkg::POS_W-1:0] pos_ext;

    assign rx_ready   = cmd.rx_en;
    assign rx_acc     = rx_valid && cmd.rx_en;
    assign is_flag    = (rx_byte == efcc_pkg::FLAG_BYTE);
    assign is_esc     = (rx_byte == efcc_pkg::ESC_BYTE) && !esc_reg;
    assign data_en    = rx_acc && !is_flag && !is_esc && sync_reg;
    assign dec_byte   = esc_reg ? (rx_byte ^ efcc_pkg::ESC_XOR) : rx_byte;
    assign frame_last = (fill_reg == LAST_IDX);

    // output stage reloads when empty or its beat is taken
    assign load = cmd.burst_en && (!out_valid_reg || out_ready);

    assign status.frame_done = data_en && frame_last;
    assign status.burst_done = load && (rd_idx_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sync_reg <= 1'b0;
            esc_reg  <= 1'b0;
            crc_reg  <= efcc_pkg::CRC_INIT;
        end
        else if (rx_acc)
        begin
            if (is_flag)
            begin
                esc_reg  <= 1'b0;
                sync_reg <= 1'b1;
                fill_reg <= '0;
                crc_reg  <= efcc_pkg::CRC_INIT;
            end
            else if (is_esc)
                esc_reg <= 1'b1;
            else if (sync_reg)
            begin
                esc_reg <= 1'b0;
                if (fill_reg < PAY_IDX)
                    crc_reg <= efcc_pkg::crc_step(crc_reg, dec_byte);
                if (frame_last)
                begin
                    sync_reg <= 1'b0;
                    fill_reg <= '0;
                end
                else
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // CRC bytes are kept aside so the check needs no store read
    always_ff @(posedge clk)
    begin
        if (data_en)
        begin
            store_mem[fill_reg] <= dec_byte;
            if (fill_reg == PAY_IDX)
                crc_hi_reg <= dec_byte;
            if (frame_last)
                ok_reg <= (crc_reg == {crc_hi_reg, dec_byte});
        end
        if (load)
        begin
            out_byte_reg <= store_mem[rd_idx_reg];
            out_idx_reg  <= rd_idx_reg;
            out_last_reg <= (rd_idx_reg == LAST_IDX);
            out_ok_reg   <= ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                rd_idx_reg    <= (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign pos_ext       = {{efcc_pkg::POS_W{1'b0}}, out_idx_reg};
    assign out_valid     = out_valid_reg;
    assign frame_byte    = out_byte_reg;
    assign byte_position = pos_ext[efcc_pkg::POS_W-1:0];
    assign last_of_frame = out_last_reg;
    assign crc_ok        = out_ok_reg;

    a_no_rx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.frame_done && cmd.burst_en))
        else $error("frame completed during output burst");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LAST_IDX)
        else $error("fill count past frame length");

    a_burst_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        status.burst_done |=> (out_valid && last_of_frame))
        else $error("final burst beat not marked last");

    a_burst_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rx_en |-> (rd_idx_reg == '0))
        else $error("read index not rewound outside burst");

endmodule

// ===== src/escaped_frame_crc_checker_core.sv =====
// Top level of the escaped frame CRC checker: controller plus datapath.
// Depends on efcc_pkg, efcc_ctrl and efcc_datapath.
//
//  channel | valid     | ready     | payload
//  rx      | rx_valid  | rx_ready  | rx_byte
//  out     | out_valid | out_ready | frame_byte, byte_position, last_of_frame, crc_ok
//
// One line byte per cycle while receiving; the frame store has one write port.
// The byte that completes a frame starts a PAYLOAD_LEN+2 beat burst, one beat per
// cycle from the store's read port unless out_ready is low; rx_ready is low until
// the last beat is loaded. Reset clears control state only; no clearing pass.
// out_ready low holds the output stage and, during a burst, the store read.
module escaped_frame_crc_checker_core #(
    parameter int PAYLOAD_LEN = efcc_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rx_valid,
    output logic                      rx_ready,
    input  logic [efcc_pkg::BYTE_W-1:0] rx_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [efcc_pkg::BYTE_W-1:0] frame_byte,
    output logic [efcc_pkg::POS_W-1:0]  byte_position,
    output logic                      last_of_frame,
    output logic                      crc_ok
);

    efcc_pkg::ctrl_cmd_t  cmd;
    efcc_pkg::dp_status_t status;

    efcc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    efcc_datapath #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last_of_frame (last_of_frame),
        .crc_ok        (crc_ok)
    );

endmodule
